### rtl/core/hcd_pkg.sv
// shared types, key codes and helpers for the hotkey chord detector
`default_nettype none
package hcd_pkg;

    localparam logic [7:0] KEY_ESC    = 8'h1B;
    localparam logic [7:0] KEY_SHIFT  = 8'h10;
    localparam logic [7:0] KEY_CTRL   = 8'h11;
    localparam logic [7:0] KEY_ALT    = 8'h12;
    localparam logic [7:0] KEY_LWIN   = 8'h5B;
    localparam logic [7:0] KEY_RWIN   = 8'h5C;
    localparam logic [7:0] KEY_LSHIFT = 8'hA0;
    localparam logic [7:0] KEY_RSHIFT = 8'hA1;
    localparam logic [7:0] KEY_LCTRL  = 8'hA2;
    localparam logic [7:0] KEY_RCTRL  = 8'hA3;
    localparam logic [7:0] KEY_LALT   = 8'hA4;
    localparam logic [7:0] KEY_RALT   = 8'hA5;

    localparam logic [3:0] BIT_ALT   = 4'h1;
    localparam logic [3:0] BIT_CTRL  = 4'h2;
    localparam logic [3:0] BIT_SHIFT = 4'h4;
    localparam logic [3:0] BIT_WIN   = 4'h8;

    typedef enum logic [1:0] {
        FUNC_KEY       = 2'd0,
        FUNC_CAP_BEGIN = 2'd1,
        FUNC_CAP_END   = 2'd2,
        FUNC_UNUSED    = 2'd3
    } t_func;

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;

    typedef enum logic [1:0] {
        REG_REQUIRED_MODS = 2'd0,
        REG_HOTKEY_CODE   = 2'd1,
        REG_TOGGLE_MODE   = 2'd2,
        REG_NONE          = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [3:0] required_mods;
        logic [7:0] hotkey_code;
        logic       toggle_mode;
    } t_cfg;

    typedef struct packed {
        logic [3:0] held_mods;
        logic       chord_active;
        logic       main_key_down;
        logic       main_key_swallowed;
        logic       win_masked;
        logic       capture_armed;
    } t_state;

    typedef struct packed {
        logic       swallow;
        logic       activate;
        logic       deactivate;
        logic       toggle_fired;
        logic       send_mask;
        logic       capture_done;
        logic       capture_cancelled;
        logic [3:0] captured_mods;
        logic [7:0] captured_key;
    } t_result;

    function automatic logic [3:0] mod_bit_of(input logic [7:0] code);
        logic [3:0] bit_v;
        case (code)
            KEY_LWIN, KEY_RWIN:               bit_v = BIT_WIN;
            KEY_CTRL, KEY_LCTRL, KEY_RCTRL:   bit_v = BIT_CTRL;
            KEY_ALT, KEY_LALT, KEY_RALT:      bit_v = BIT_ALT;
            KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT: bit_v = BIT_SHIFT;
            default:                          bit_v = 4'h0;
        endcase
        return bit_v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/hcd_if.sv
// valid/ready channels for key words and result words
`default_nettype none
interface hcd_key_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] key_code;
    logic [1:0] event_kind;

    modport source (output valid, output func, output key_code, output event_kind,
                    input ready);
    modport sink (input valid, input func, input key_code, input event_kind,
                  output ready);
endinterface

interface hcd_res_if;
    logic       valid;
    logic       ready;
    logic       swallow;
    logic       activate;
    logic       deactivate;
    logic       toggle_fired;
    logic       send_mask;
    logic       capture_done;
    logic       capture_cancelled;
    logic [3:0] captured_mods;
    logic [7:0] captured_key;

    modport source (output valid, output swallow, output activate, output deactivate,
                    output toggle_fired, output send_mask, output capture_done,
                    output capture_cancelled, output captured_mods,
                    output captured_key, input ready);
    modport sink (input valid, input swallow, input activate, input deactivate,
                  input toggle_fired, input send_mask, input capture_done,
                  input capture_cancelled, input captured_mods, input captured_key,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/hcd_step.sv
// next-state and result logic for one key word
`default_nettype none
module hcd_step
    import hcd_pkg::*;
(
    input  wire t_cfg       i_cfg,
    input  wire t_state     i_state,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_key_code,
    input  wire logic [1:0] i_event_kind,
    output t_state          o_state,
    output t_result         o_result
);

    always_comb begin
        t_state     s;
        t_result    r;
        logic [3:0] bit_v;
        logic       down;
        logic       up;
        logic       match;
        logic       sat;
        logic       old_sw;

        s      = i_state;
        r      = '0;
        bit_v  = mod_bit_of(i_key_code);
        down   = (i_event_kind == KIND_DOWN);
        up     = (i_event_kind == KIND_UP);
        match  = (i_state.held_mods == i_cfg.required_mods);
        sat    = 1'b0;
        old_sw = i_state.main_key_swallowed;

        case (t_func'(i_func))
            FUNC_CAP_BEGIN: s.capture_armed = 1'b1;
            FUNC_CAP_END:   s.capture_armed = 1'b0;
            FUNC_KEY: begin
                if (bit_v != 4'h0) begin
                    if (down) begin
                        s.held_mods = s.held_mods | bit_v;
                    end else if (up) begin
                        s.held_mods = s.held_mods & ~bit_v;
                    end
                    if (bit_v == BIT_WIN && up) begin
                        s.win_masked = 1'b0;
                    end
                    if (!s.capture_armed && !i_cfg.toggle_mode) begin
                        sat = (s.held_mods == i_cfg.required_mods) && s.main_key_down;
                        if (sat && !s.chord_active) begin
                            s.chord_active = 1'b1;
                            r.activate     = 1'b1;
                            if (i_cfg.required_mods[3] && !s.win_masked) begin
                                r.send_mask  = 1'b1;
                                s.win_masked = 1'b1;
                            end
                        end else if (!sat && s.chord_active) begin
                            s.chord_active = 1'b0;
                            r.deactivate   = 1'b1;
                        end
                    end
                end else if (s.capture_armed) begin
                    r.swallow = 1'b1;
                    if (down) begin
                        s.capture_armed = 1'b0;
                        r.capture_done  = 1'b1;
                        if (i_key_code == KEY_ESC) begin
                            r.capture_cancelled = 1'b1;
                        end else begin
                            r.captured_mods = s.held_mods;
                            r.captured_key  = i_key_code;
                            if (s.held_mods[3] && !s.win_masked) begin
                                r.send_mask  = 1'b1;
                                s.win_masked = 1'b1;
                            end
                        end
                    end
                end else if (i_key_code == i_cfg.hotkey_code) begin
                    if (i_cfg.toggle_mode) begin
                        if (down) begin
                            if (match && !s.main_key_down) begin
                                s.main_key_down      = 1'b1;
                                s.main_key_swallowed = 1'b1;
                                r.toggle_fired       = 1'b1;
                                r.swallow            = 1'b1;
                                if (i_cfg.required_mods[3] && !s.win_masked) begin
                                    r.send_mask  = 1'b1;
                                    s.win_masked = 1'b1;
                                end
                            end else if (s.main_key_down) begin
                                r.swallow = 1'b1;
                            end
                        end else if (up) begin
                            s.main_key_down      = 1'b0;
                            s.main_key_swallowed = 1'b0;
                            r.swallow            = old_sw;
                        end
                    end else if (down || up) begin
                        if (down && match) begin
                            s.main_key_down      = 1'b1;
                            s.main_key_swallowed = 1'b1;
                            r.swallow            = 1'b1;
                        end else if (up) begin
                            s.main_key_down      = 1'b0;
                            s.main_key_swallowed = 1'b0;
                            r.swallow            = old_sw;
                        end
                        if (up || match) begin
                            sat = match && s.main_key_down;
                            if (sat && !s.chord_active) begin
                                s.chord_active = 1'b1;
                                r.activate     = 1'b1;
                                if (i_cfg.required_mods[3] && !s.win_masked) begin
                                    r.send_mask  = 1'b1;
                                    s.win_masked = 1'b1;
                                end
                            end else if (!sat && s.chord_active) begin
                                s.chord_active = 1'b0;
                                r.deactivate   = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        o_state  = s;
        o_result = r;
    end

endmodule
`default_nettype wire

### rtl/core/hotkey_chord_detector_unit.sv
// top level of the hotkey chord detector: config registers, state and result register
`default_nettype none
// Each accepted key word is evaluated combinationally against the held
// modifiers and the chord state and produces exactly one result word, which
// sits in a single output register. A new key word is accepted every cycle
// while the result register is empty or being drained in the same cycle, so
// the block sustains one word per clock; the registered result appears in the
// cycle after acceptance. Configuration writes take effect at once and clear
// the chord tracking flags; write them only while no result is pending.
module hotkey_chord_detector_unit
    import hcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    hcd_key_if.sink         i_key,
    hcd_res_if.source       o_res
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_res_valid;
    logic    accept;

    assign i_key.ready = !r_res_valid || o_res.ready;
    assign accept      = i_key.valid && i_key.ready;

    hcd_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_func       (i_key.func),
        .i_key_code   (i_key.key_code),
        .i_event_kind (i_key.event_kind),
        .o_state      (n_state),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_state <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_REQUIRED_MODS: r_cfg.required_mods <= i_cfg_data[3:0];
                REG_HOTKEY_CODE:   r_cfg.hotkey_code   <= i_cfg_data;
                REG_TOGGLE_MODE:   r_cfg.toggle_mode   <= i_cfg_data[0];
                default: ;
            endcase
            if (t_reg_idx'(i_cfg_index) != REG_NONE) begin
                r_state.chord_active       <= 1'b0;
                r_state.main_key_down      <= 1'b0;
                r_state.main_key_swallowed <= 1'b0;
            end
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid             = r_res_valid;
    assign o_res.swallow           = r_res.swallow;
    assign o_res.activate          = r_res.activate;
    assign o_res.deactivate        = r_res.deactivate;
    assign o_res.toggle_fired      = r_res.toggle_fired;
    assign o_res.send_mask         = r_res.send_mask;
    assign o_res.capture_done      = r_res.capture_done;
    assign o_res.capture_cancelled = r_res.capture_cancelled;
    assign o_res.captured_mods     = r_res.captured_mods;
    assign o_res.captured_key      = r_res.captured_key;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_res.ready) |-> !i_key.ready)
        else $error("key word accepted while result word stalled");

    a_activate_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_we && n_res.activate) |=> r_state.chord_active)
        else $error("activate without chord becoming active");

    a_mask_is_one_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.send_mask) |-> r_state.win_masked)
        else $error("mask request without win masked flag");

endmodule
`default_nettype wire
